// File: sv/slir_pkg.sv
// Shared types, codes and widths for the sorted insertion list.
package slir_pkg;

	localparam int CAPACITY_DEF = 16;

	localparam int VAL_W       = 32;
	localparam int IDX_W       = 4;
	localparam int CNT_OUT_W   = 5;
	localparam int FUNC_W      = 2;
	localparam int ST_W        = 2;
	localparam int S_TDATA_W   = 40;
	localparam int M_TDATA_W   = 40;
	localparam int S_TUSER_W   = FUNC_W;
	localparam int M_TUSER_W   = ST_W;
	localparam int S_PAD_W     = S_TDATA_W - VAL_W - IDX_W;
	localparam int M_PAD_W     = M_TDATA_W - VAL_W - CNT_OUT_W;
	localparam int RD_SPAN     = 1 << IDX_W;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_READ   = 2'd1,
		FUNC_REMOVE = 2'd2
	} func_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic ins;
		logic rmv;
	} cell_ctl_t;

endpackage

// File: sv/sorted_list_insert_remove_top.sv
// Top level of the sorted insertion list: request decode, cell row and result register.
//
//  channel  dir  tdata                          tuser
//  s_*      in   value[31:0] index[35:32]       func[1:0]
//  m_*      out  data[31:0] count[36:32]        status[1:0]
//
// One request per cycle while the output is not stalled: every cell compares against the
// new value at once and shifts with its neighbor on the same edge that accepts the request.
// The result lands in the output register in the cycle after the request beat.
// Reset clears the entry count and the output valid; entries are not cleared.
// A stalled result holds and blocks the next request only while it waits.
module sorted_list_insert_remove_top #(
	parameter int CAPACITY = slir_pkg::CAPACITY_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [slir_pkg::S_TDATA_W-1:0] s_tdata,  // value[31:0], index[35:32], zero pad
	input  logic [slir_pkg::S_TUSER_W-1:0] s_tuser,  // func[1:0]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [slir_pkg::M_TDATA_W-1:0] m_tdata,  // data[31:0], count[36:32], zero pad
	output logic [slir_pkg::M_TUSER_W-1:0] m_tuser   // status[1:0]
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CW    = (CNT_W > slir_pkg::IDX_W) ? CNT_W : slir_pkg::IDX_W;
	localparam int OW    = (CNT_W > slir_pkg::CNT_OUT_W) ? CNT_W : slir_pkg::CNT_OUT_W;
	localparam int RD_N  = (CAPACITY < slir_pkg::RD_SPAN) ? CAPACITY : slir_pkg::RD_SPAN;

	logic [CNT_W-1:0]              cnt_q;
	logic [CNT_W-1:0]              cnt_nxt;
	logic                          m_tvalid_q;
	logic [slir_pkg::VAL_W-1:0]    m_data_q;
	logic [CNT_W-1:0]              m_cnt_q;
	logic [slir_pkg::ST_W-1:0]     m_status_q;

	logic [slir_pkg::VAL_W-1:0]    s_value;
	logic [slir_pkg::IDX_W-1:0]    s_index;
	slir_pkg::func_t               s_func;
	logic                          acc;
	logic                          full;
	logic                          idx_ok;
	logic                          ins_go;
	logic                          rmv_go;
	logic [slir_pkg::VAL_W-1:0]    rd_data;
	logic [slir_pkg::VAL_W-1:0]    res_data;
	slir_pkg::status_t             res_status;
	logic [OW-1:0]                 cnt_out;
	slir_pkg::cell_ctl_t           ctl;

	logic [slir_pkg::VAL_W-1:0]    cell_data [CAPACITY];
	logic [CAPACITY-1:0]           cell_le;

	assign s_value  = s_tdata[slir_pkg::VAL_W-1:0];
	assign s_index  = s_tdata[slir_pkg::VAL_W +: slir_pkg::IDX_W];
	assign s_func   = slir_pkg::func_t'(s_tuser);
	assign s_tready = !m_tvalid_q || m_tready;
	assign acc      = s_tvalid && s_tready;
	assign full     = (cnt_q == CNT_W'(CAPACITY));
	assign idx_ok   = (CW'(s_index) < CW'(cnt_q));
	assign ins_go   = acc && (s_func == slir_pkg::FUNC_INSERT) && !full;
	assign rmv_go   = acc && (s_func == slir_pkg::FUNC_REMOVE) && idx_ok;
	assign ctl      = '{ins: ins_go, rmv: rmv_go};

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                       l_le;
		logic [slir_pkg::VAL_W-1:0] l_data;
		logic [slir_pkg::VAL_W-1:0] r_data;

		if (i == 0) begin : g_head
			assign l_le   = 1'b1;
			assign l_data = s_value;
		end else begin : g_body
			assign l_le   = cell_le[i-1];
			assign l_data = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign r_data = cell_data[i];
		end else begin : g_inner
			assign r_data = cell_data[i+1];
		end

		slir_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.new_value  (s_value),
			.occ        (CNT_W'(i) < cnt_q),
			.past_idx   (CW'(i) >= CW'(s_index)),
			.left_le    (l_le),
			.left_data  (l_data),
			.right_data (r_data),
			.le         (cell_le[i]),
			.data       (cell_data[i])
		);
	end

	always_comb begin
		rd_data = '0;
		for (int i = 0; i < RD_N; i++) begin
			if (s_index == slir_pkg::IDX_W'(i)) begin
				rd_data = cell_data[i];
			end
		end
	end

	always_comb begin
		cnt_nxt    = cnt_q;
		res_data   = '0;
		res_status = slir_pkg::ST_OK;
		unique case (s_func) inside
			slir_pkg::FUNC_INSERT: begin
				if (full) begin
					res_status = slir_pkg::ST_FULL;
				end else begin
					cnt_nxt = cnt_q + CNT_W'(1);
				end
			end
			slir_pkg::FUNC_READ, slir_pkg::FUNC_REMOVE: begin
				if (!idx_ok) begin
					res_status = slir_pkg::ST_RANGE;
				end else begin
					res_data = rd_data;
					if (s_func == slir_pkg::FUNC_REMOVE) begin
						cnt_nxt = cnt_q - CNT_W'(1);
					end
				end
			end
			default: begin
				res_status = slir_pkg::ST_RANGE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (acc) begin
				cnt_q <= cnt_nxt;
			end
			if (s_tready) begin
				m_tvalid_q <= s_tvalid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			m_data_q   <= res_data;
			m_cnt_q    <= cnt_nxt;
			m_status_q <= res_status;
		end
	end

	assign cnt_out  = OW'(m_cnt_q);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{slir_pkg::M_PAD_W{1'b0}}, cnt_out[slir_pkg::CNT_OUT_W-1:0], m_data_q};
	assign m_tuser  = m_status_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("entry count past capacity");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (s_func == slir_pkg::FUNC_INSERT) && full
		|=> m_tvalid && (m_status_q == slir_pkg::ST_FULL) && (cnt_q == $past(cnt_q)))
		else $error("insert into full list not dropped");

	a_ins_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		ins_go |=> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("insert did not grow the list");

	a_rmv_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rmv_go |=> cnt_q == $past(cnt_q) - CNT_W'(1))
		else $error("remove did not shrink the list");

	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q >= CNT_W'(2) |-> $signed(cell_data[0]) <= $signed(cell_data[1]))
		else $error("head entries out of order");

endmodule

// File: sv/slir_cell.sv
// One list cell: holds one entry, compares it with the new value, shifts with its neighbors.
module slir_cell (
	input  logic                      clk,
	input  slir_pkg::cell_ctl_t       ctl,
	input  logic [slir_pkg::VAL_W-1:0] new_value,
	input  logic                      occ,
	input  logic                      past_idx,
	input  logic                      left_le,
	input  logic [slir_pkg::VAL_W-1:0] left_data,
	input  logic [slir_pkg::VAL_W-1:0] right_data,
	output logic                      le,
	output logic [slir_pkg::VAL_W-1:0] data
);

	logic [slir_pkg::VAL_W-1:0] data_q;

	assign le   = occ && ($signed(data_q) <= $signed(new_value));
	assign data = data_q;

	always_ff @(posedge clk) begin
		if (ctl.ins && !le) begin
			data_q <= left_le ? new_value : left_data;
		end else if (ctl.rmv && past_idx) begin
			data_q <= right_data;
		end
	end

endmodule

// File: sim/sorted_list_insert_remove_top_tb.sv
// Testbench for the sorted insertion list: directed and random requests checked against a list model.
module sorted_list_insert_remove_top_tb;

	localparam logic [slir_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int CAP = slir_pkg::CAPACITY_DEF;
	localparam int PHASE_ITEMS = 230;
	localparam int MODE_ITEMS = 40;
	localparam int HOLD_CYCLES = 80;
	localparam int DRAIN_CYCLES = 10;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic signed [slir_pkg::VAL_W-1:0] data;
		logic [slir_pkg::CNT_OUT_W-1:0]    count;
		slir_pkg::status_t                 status;
	} list_result_t;

	class sorted_list_tracker;
		logic signed [slir_pkg::VAL_W-1:0] held[$];
		list_result_t                      pending[$];
		int                                errors;

		function void note_request(logic [slir_pkg::FUNC_W-1:0] func,
				logic signed [slir_pkg::VAL_W-1:0] value, logic [slir_pkg::IDX_W-1:0] index);
			list_result_t res;
			int pos;
			res.data = '0;
			res.status = slir_pkg::ST_OK;
			if (func == slir_pkg::FUNC_INSERT) begin
				if (held.size() >= CAP) begin
					res.status = slir_pkg::ST_FULL;
				end else begin
					pos = 0;
					while (pos < held.size() && held[pos] <= value)
						pos++;
					held.insert(pos, value);
				end
			end else if (func == slir_pkg::FUNC_READ || func == slir_pkg::FUNC_REMOVE) begin
				if (index >= held.size()) begin
					res.status = slir_pkg::ST_RANGE;
				end else begin
					res.data = held[index];
					if (func == slir_pkg::FUNC_REMOVE)
						held.delete(index);
				end
			end else begin
				res.status = slir_pkg::ST_RANGE;
			end
			res.count = slir_pkg::CNT_OUT_W'(held.size());
			pending.push_back(res);
		endfunction

		function void check_result(logic signed [slir_pkg::VAL_W-1:0] data,
				logic [slir_pkg::CNT_OUT_W-1:0] count, logic [slir_pkg::ST_W-1:0] status);
			list_result_t want;
			if (pending.size() == 0) begin
				$error("result beat with nothing outstanding: data %0d count %0d status %0d",
					data, count, status);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (data !== want.data) begin
				$error("data: expected %0d, got %0d", want.data, data);
				errors++;
			end
			if (count !== want.count) begin
				$error("count: expected %0d, got %0d", want.count, count);
				errors++;
			end
			if (status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, status);
				errors++;
			end
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [slir_pkg::S_TDATA_W-1:0] s_tdata = '0;
	logic [slir_pkg::S_TUSER_W-1:0] s_tuser = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [slir_pkg::M_TDATA_W-1:0] m_tdata;
	logic [slir_pkg::M_TUSER_W-1:0] m_tuser;

	sorted_list_tracker tracker = new();
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int hold_requests = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int cycles = 0;

	sorted_list_insert_remove_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (hold_requests != hold_seen) begin
			hold_seen = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99, 0) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_result(m_tdata[slir_pkg::VAL_W-1:0],
				m_tdata[slir_pkg::VAL_W +: slir_pkg::CNT_OUT_W], m_tuser);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[sorted_list_insert_remove_top] ERROR");
			$finish;
		end
	end

	task automatic send_request(input logic [slir_pkg::FUNC_W-1:0] func,
			input logic signed [slir_pkg::VAL_W-1:0] value,
			input logic [slir_pkg::IDX_W-1:0] index);
		while ($urandom_range(99, 0) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{slir_pkg::S_PAD_W{1'b0}}, index, value};
		s_tuser <= func;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tracker.note_request(func, value, index);
	endtask

	task automatic send_random(input int insert_pct);
		logic [slir_pkg::FUNC_W-1:0]       func;
		logic signed [slir_pkg::VAL_W-1:0] value;
		logic [slir_pkg::IDX_W-1:0]        index;
		int                                roll;
		int                                held_n;
		held_n = tracker.held.size();
		roll = $urandom_range(99, 0);
		if (roll < 3)
			func = FUNC_UNUSED;
		else if (roll < 3 + insert_pct)
			func = slir_pkg::FUNC_INSERT;
		else if ($urandom_range(1, 0) == 0)
			func = slir_pkg::FUNC_READ;
		else
			func = slir_pkg::FUNC_REMOVE;
		case ($urandom_range(3, 0))
			0, 1: value = int'($urandom_range(6, 0)) - 3;
			2: value = $urandom;
			default: begin
				if ($urandom_range(1, 0) == 0)
					value = 32'sh7FFF_FFFF - int'($urandom_range(3, 0));
				else
					value = 32'sh8000_0000 + int'($urandom_range(3, 0));
			end
		endcase
		if (held_n > 0 && $urandom_range(9, 0) != 0)
			index = slir_pkg::IDX_W'($urandom_range(held_n - 1, 0));
		else
			index = slir_pkg::IDX_W'($urandom_range(15, 0));
		send_request(func, value, index);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (tracker.pending.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int idle_by_phase[5];
		int stall_by_phase[5];
		int insert_by_mode[3];
		idle_by_phase = '{0, 59, 0, 13, 0};
		stall_by_phase = '{0, 0, 59, 13, 0};
		insert_by_mode = '{70, 25, 45};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(slir_pkg::FUNC_READ, 0, 0);
		send_request(slir_pkg::FUNC_REMOVE, 0, 15);
		send_request(FUNC_UNUSED, -1, 15);
		send_request(slir_pkg::FUNC_INSERT, 32'sh7FFF_FFFF, 0);
		send_request(slir_pkg::FUNC_INSERT, 32'sh8000_0000, 0);
		send_request(slir_pkg::FUNC_INSERT, 0, 0);
		send_request(slir_pkg::FUNC_INSERT, 0, 0);
		send_request(slir_pkg::FUNC_READ, 0, 0);
		send_request(slir_pkg::FUNC_READ, 0, 3);
		send_request(slir_pkg::FUNC_REMOVE, 0, 1);
		send_request(slir_pkg::FUNC_READ, 0, 3);
		send_request(slir_pkg::FUNC_INSERT, -1, 0);
		send_request(slir_pkg::FUNC_INSERT, 1, 0);
		for (int k = 0; k < 11; k++)
			send_request(slir_pkg::FUNC_INSERT, $urandom, 0);
		send_request(slir_pkg::FUNC_INSERT, 32'sh5555_5555, 0);
		send_request(slir_pkg::FUNC_READ, 0, 15);
		send_request(slir_pkg::FUNC_REMOVE, 0, 15);
		send_request(slir_pkg::FUNC_REMOVE, 0, 0);
		wait_drained();

		for (int ph = 0; ph < 5; ph++) begin
			src_idle_pct = idle_by_phase[ph];
			sink_stall_pct = stall_by_phase[ph];
			if (ph == 0 || ph == 3)
				hold_requests++;
			for (int k = 0; k < PHASE_ITEMS; k++)
				send_random(insert_by_mode[(k / MODE_ITEMS) % 3]);
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.errors == 0)
			$display("[sorted_list_insert_remove_top] OK");
		else
			$display("[sorted_list_insert_remove_top] ERROR");
		$finish;
	end

endmodule
